[rtl/nps_pkg.sv]
// Shared types and codes for the node pool mark-and-sweep core.
// No dependencies; every other file in rtl uses it.
package nps_pkg;

	localparam int OP_W     = 2;
	localparam int STATUS_W = 3;
	localparam int OWNER_W  = 2;
	localparam int KEY_IO_W = 32;

	typedef logic [OP_W-1:0]     opcode_t;
	typedef logic [STATUS_W-1:0] status_t;
	typedef logic [OWNER_W-1:0]  owner_t;

	localparam opcode_t OP_INSERT  = 2'd0;
	localparam opcode_t OP_DELETE  = 2'd1;
	localparam opcode_t OP_COLLECT = 2'd2;
	localparam opcode_t OP_READ    = 2'd3;

	localparam status_t ST_INSERTED  = 3'd0;
	localparam status_t ST_EMPTY_GC  = 3'd1;
	localparam status_t ST_DELETED   = 3'd2;
	localparam status_t ST_NOT_FOUND = 3'd3;
	localparam status_t ST_COLLECTED = 3'd4;
	localparam status_t ST_READ      = 3'd5;

	localparam owner_t OWN_FREE    = 2'd0;
	localparam owner_t OWN_LIST1   = 2'd1;
	localparam owner_t OWN_LIST2   = 2'd2;
	localparam owner_t OWN_UNREACH = 2'd3;

endpackage

[rtl/nps_req_if.sv]
// Request channel of the node pool core: valid/ready plus one command word.
// Depends on nps_pkg for field widths.
interface nps_req_if #(parameter int NODE_W = 5);
	logic                          valid;
	logic                          ready;
	nps_pkg::opcode_t              opcode;
	logic                          list_select;
	logic [nps_pkg::KEY_IO_W-1:0]  key_value;
	logic [NODE_W-1:0]             node_number;

	modport source (output valid, output opcode, output list_select, output key_value,
		output node_number, input ready);
	modport sink (input valid, input opcode, input list_select, input key_value,
		input node_number, output ready);
endinterface

[rtl/nps_rsp_if.sv]
// Response channel of the node pool core: valid/ready plus one result word.
// Depends on nps_pkg for field widths.
interface nps_rsp_if #(parameter int NODE_W = 5);
	logic                          valid;
	logic                          ready;
	nps_pkg::status_t              status;
	logic [NODE_W-1:0]             affected_node;
	logic [NODE_W-1:0]             node_count;
	logic [nps_pkg::KEY_IO_W-1:0]  read_key;
	logic [NODE_W-1:0]             read_next;
	nps_pkg::owner_t               read_owner;

	modport source (output valid, output status, output affected_node, output node_count,
		output read_key, output read_next, output read_owner, input ready);
	modport sink (input valid, input status, input affected_node, input node_count,
		input read_key, input read_next, input read_owner, output ready);
endinterface

[rtl/node_pool_mark_sweep_core.sv]
// Node pool with free list, two linked lists and mark-and-sweep collection; uses nps_pkg,
// nps_req_if and nps_rsp_if. An insert writes the node and, when the list is not empty,
// links it behind the tail; a delete walks the whole list; a collect scans every node and
// then walks the free chain. The next word can be taken in the cycle rsp.valid rises, and
// a held result keeps the core waiting. The walks run at one node per cycle. After reset a
// clearing pass over all POOL_NODES nodes initializes the memories before any word.
module node_pool_mark_sweep_core #(
	parameter int POOL_NODES = 16,
	parameter int KEY_BITS   = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	nps_req_if.sink    req,
	nps_rsp_if.source  rsp
);

	// Node numbers run 1..POOL_NODES with 0 meaning none; memory address is number - 1.
	localparam int NW = $clog2(POOL_NODES + 1);
	localparam int AW = $clog2(POOL_NODES);
	localparam logic [NW-1:0] POOL_N = NW'(POOL_NODES);
	localparam logic [NW:0]   POOL_X = (NW+1)'(POOL_NODES);
	localparam logic [AW-1:0] LAST_A = AW'(POOL_NODES - 1);

	localparam logic [3:0] S_INIT     = 4'd0;
	localparam logic [3:0] S_IDLE     = 4'd1;
	localparam logic [3:0] S_INS_WR   = 4'd2;
	localparam logic [3:0] S_INS_LINK = 4'd3;
	localparam logic [3:0] S_DEL      = 4'd4;
	localparam logic [3:0] S_CSCAN    = 4'd5;
	localparam logic [3:0] S_CWALK    = 4'd6;
	localparam logic [3:0] S_CEND     = 4'd7;
	localparam logic [3:0] S_READ     = 4'd8;
	localparam logic [3:0] S_DONE     = 4'd9;

	function automatic logic node_ok(input logic [NW-1:0] n);
		return (n != '0) && (n <= POOL_N);
	endfunction

	function automatic logic [AW-1:0] node_addr(input logic [NW-1:0] n);
		logic [NW-1:0] m;
		m = n - 1'b1;
		return m[AW-1:0];
	endfunction

	// Node memories: one shared read address, a write port per memory.
	logic [KEY_BITS-1:0]  key_mem  [POOL_NODES];
	logic [NW-1:0]        link_mem [POOL_NODES];
	nps_pkg::owner_t      own_mem  [POOL_NODES];

	logic [AW-1:0]        rd_addr;
	logic [KEY_BITS-1:0]  key_rd_q;
	logic [NW-1:0]        link_rd_q;
	nps_pkg::owner_t      own_rd_q;

	logic                 key_we, link_we, own_we;
	logic [AW-1:0]        key_wa, link_wa, own_wa;
	logic [KEY_BITS-1:0]  key_wd;
	logic [NW-1:0]        link_wd;
	nps_pkg::owner_t      own_wd;

	always_ff @(posedge clk) begin
		if (key_we) key_mem[key_wa] <= key_wd;
		if (link_we) link_mem[link_wa] <= link_wd;
		if (own_we) own_mem[own_wa] <= own_wd;
		key_rd_q  <= key_mem[rd_addr];
		link_rd_q <= link_mem[rd_addr];
		own_rd_q  <= own_mem[rd_addr];
	end

	// Control state.
	logic [3:0]           state_q, state_d;
	logic [AW-1:0]        init_q, init_d;
	logic                 sel_q, sel_d;
	logic [KEY_BITS-1:0]  key_q, key_d;
	logic [NW-1:0]        cur_q, cur_d;
	logic [NW-1:0]        prev_q, prev_d;
	logic [NW-1:0]        steps_q, steps_d;
	logic [NW-1:0]        last_q, last_d;
	logic [NW-1:0]        first_q, first_d;
	logic [NW-1:0]        total_q, total_d;
	logic [NW-1:0]        cnt_q, cnt_d;
	logic [NW-1:0]        free_head_q, free_head_d;
	logic [NW-1:0]        free_count_q, free_count_d;
	logic [NW-1:0]        head_q [2];
	logic [NW-1:0]        head_d [2];
	logic [NW-1:0]        tail_q [2];
	logic [NW-1:0]        tail_d [2];

	// Result held until the output register is free.
	nps_pkg::status_t             res_status_q, res_status_d;
	logic [NW-1:0]                res_aff_q, res_aff_d;
	logic [NW-1:0]                res_cnt_q, res_cnt_d;
	logic [nps_pkg::KEY_IO_W-1:0] res_key_q, res_key_d;
	logic [NW-1:0]                res_next_q, res_next_d;
	nps_pkg::owner_t              res_own_q, res_own_d;

	logic out_valid_q, out_valid_d, out_load;

	always_comb begin
		logic [63:0]        kin;
		logic signed [63:0] kwide;
		logic               app_en;
		logic [NW-1:0]      app_n;
		logic [NW-1:0]      tot_n;
		logic [NW-1:0]      nxt;
		logic [NW:0]        st1;
		logic [NW-1:0]      cnt_n;

		kin    = {{32{req.key_value[31]}}, req.key_value};
		kwide  = 64'(signed'(key_rd_q));
		app_en = 1'b0;
		app_n  = '0;
		tot_n  = total_q + 1'b1;
		nxt    = link_rd_q;
		st1    = {1'b0, steps_q} + 1'b1;
		cnt_n  = cnt_q;

		state_d      = state_q;
		init_d       = init_q;
		sel_d        = sel_q;
		key_d        = key_q;
		cur_d        = cur_q;
		prev_d       = prev_q;
		steps_d      = steps_q;
		last_d       = last_q;
		first_d      = first_q;
		total_d      = total_q;
		cnt_d        = cnt_q;
		free_head_d  = free_head_q;
		free_count_d = free_count_q;
		head_d       = head_q;
		tail_d       = tail_q;
		res_status_d = res_status_q;
		res_aff_d    = res_aff_q;
		res_cnt_d    = res_cnt_q;
		res_key_d    = res_key_q;
		res_next_d   = res_next_q;
		res_own_d    = res_own_q;
		out_load     = 1'b0;

		rd_addr = '0;
		key_we  = 1'b0; key_wa  = '0; key_wd  = '0;
		link_we = 1'b0; link_wa = '0; link_wd = '0;
		own_we  = 1'b0; own_wa  = '0; own_wd  = nps_pkg::OWN_FREE;

		req.ready = (state_q == S_IDLE);

		unique case (state_q)
			S_INIT: begin
				// Clearing pass: free chain 1 -> 2 -> ... -> last, keys zero.
				key_we  = 1'b1; key_wa  = init_q;
				link_we = 1'b1; link_wa = init_q;
				link_wd = (init_q == LAST_A) ? '0 : NW'(init_q) + NW'(2);
				own_we  = 1'b1; own_wa  = init_q;
				init_d  = init_q + 1'b1;
				if (init_q == LAST_A) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (req.valid) begin
					sel_d        = req.list_select;
					key_d        = kin[KEY_BITS-1:0];
					res_status_d = nps_pkg::ST_READ;
					res_aff_d    = '0;
					res_cnt_d    = '0;
					res_key_d    = '0;
					res_next_d   = '0;
					res_own_d    = nps_pkg::OWN_FREE;
					cnt_d        = '0;
					prev_d       = '0;
					steps_d      = '0;
					last_d       = '0;
					first_d      = '0;
					total_d      = '0;
					unique case (req.opcode)
						nps_pkg::OP_INSERT: begin
							if (free_count_q == '0 || !node_ok(free_head_q)) begin
								res_status_d = nps_pkg::ST_EMPTY_GC;
								rd_addr      = LAST_A;
								cur_d        = POOL_N;
								state_d      = S_CSCAN;
							end else begin
								res_status_d = nps_pkg::ST_INSERTED;
								rd_addr      = node_addr(free_head_q);
								cur_d        = free_head_q;
								state_d      = S_INS_WR;
							end
						end
						nps_pkg::OP_DELETE: begin
							cur_d = head_q[req.list_select];
							if (node_ok(head_q[req.list_select])) begin
								rd_addr = node_addr(head_q[req.list_select]);
								state_d = S_DEL;
							end else begin
								res_status_d = nps_pkg::ST_NOT_FOUND;
								state_d      = S_DONE;
							end
						end
						nps_pkg::OP_COLLECT: begin
							res_status_d = nps_pkg::ST_COLLECTED;
							rd_addr      = LAST_A;
							cur_d        = POOL_N;
							state_d      = S_CSCAN;
						end
						default: begin
							cur_d = req.node_number;
							if (node_ok(req.node_number)) begin
								rd_addr = node_addr(req.node_number);
								state_d = S_READ;
							end else begin
								state_d = S_DONE;
							end
						end
					endcase
				end
			end
			S_INS_WR: begin
				free_head_d  = link_rd_q;
				free_count_d = free_count_q - 1'b1;
				key_we  = 1'b1; key_wa  = node_addr(cur_q); key_wd = key_q;
				link_we = 1'b1; link_wa = node_addr(cur_q); link_wd = '0;
				own_we  = 1'b1; own_wa  = node_addr(cur_q);
				own_wd  = nps_pkg::OWN_LIST1 + nps_pkg::owner_t'(sel_q);
				res_aff_d = cur_q;
				if (node_ok(tail_q[sel_q])) begin
					state_d = S_INS_LINK;
				end else begin
					head_d[sel_q] = cur_q;
					tail_d[sel_q] = cur_q;
					state_d       = S_DONE;
				end
			end
			S_INS_LINK: begin
				link_we = 1'b1; link_wa = node_addr(tail_q[sel_q]); link_wd = cur_q;
				tail_d[sel_q] = cur_q;
				state_d       = S_DONE;
			end
			S_DEL: begin
				// Evaluate cur_q and issue the read of its successor in the same cycle.
				if (key_rd_q == key_q) begin
					if (prev_q == '0) begin
						head_d[sel_q] = nxt;
					end else begin
						link_we = 1'b1; link_wa = node_addr(prev_q); link_wd = nxt;
					end
					if (tail_q[sel_q] == cur_q) tail_d[sel_q] = prev_q;
					own_we = 1'b1; own_wa = node_addr(cur_q); own_wd = nps_pkg::OWN_UNREACH;
					cnt_n  = cnt_q + 1'b1;
				end else begin
					prev_d = cur_q;
				end
				cnt_d = cnt_n;
				if (st1 < POOL_X && node_ok(nxt)) begin
					rd_addr = node_addr(nxt);
					cur_d   = nxt;
					steps_d = st1[NW-1:0];
				end else begin
					res_cnt_d    = cnt_n;
					res_status_d = (cnt_n != '0) ? nps_pkg::ST_DELETED : nps_pkg::ST_NOT_FOUND;
					state_d      = S_DONE;
				end
			end
			S_CSCAN: begin
				// Mark phase: nodes scanned from the top, unreachable ones chained first.
				if (own_rd_q == nps_pkg::OWN_UNREACH) begin
					app_en = 1'b1;
					app_n  = cur_q;
					cnt_d  = cnt_q + 1'b1;
				end else begin
					tot_n = total_q;
				end
				if (cur_q > NW'(1)) begin
					rd_addr = node_addr(cur_q - 1'b1);
					cur_d   = cur_q - 1'b1;
				end else if (free_count_q != '0 && tot_n < POOL_N && node_ok(free_head_q)) begin
					rd_addr = node_addr(free_head_q);
					cur_d   = free_head_q;
					steps_d = '0;
					state_d = S_CWALK;
				end else begin
					state_d = S_CEND;
				end
			end
			S_CWALK: begin
				// Sweep phase: the old free chain follows the reclaimed nodes.
				if (own_rd_q != nps_pkg::OWN_FREE) begin
					state_d = S_CEND;
				end else begin
					app_en = 1'b1;
					app_n  = cur_q;
					if (st1 < {1'b0, free_count_q} && st1 < POOL_X && tot_n < POOL_N
						&& node_ok(nxt)) begin
						rd_addr = node_addr(nxt);
						cur_d   = nxt;
						steps_d = st1[NW-1:0];
					end else begin
						state_d = S_CEND;
					end
				end
			end
			S_CEND: begin
				if (last_q != '0) begin
					link_we = 1'b1; link_wa = node_addr(last_q); link_wd = '0;
				end
				free_head_d  = first_q;
				free_count_d = total_q;
				res_cnt_d    = cnt_q;
				state_d      = S_DONE;
			end
			S_READ: begin
				res_aff_d  = cur_q;
				res_key_d  = kwide[nps_pkg::KEY_IO_W-1:0];
				res_next_d = link_rd_q;
				res_own_d  = own_rd_q;
				state_d    = S_DONE;
			end
			S_DONE: begin
				if (!out_valid_q || rsp.ready) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase

		// Appending a node to the rebuilt free chain: clear it and link it behind the last one.
		if (app_en) begin
			if (last_q == '0) begin
				first_d = app_n;
			end else begin
				link_we = 1'b1; link_wa = node_addr(last_q); link_wd = app_n;
			end
			own_we  = 1'b1; own_wa = node_addr(app_n); own_wd = nps_pkg::OWN_FREE;
			key_we  = 1'b1; key_wa = node_addr(app_n); key_wd = '0;
			last_d  = app_n;
			total_d = total_q + 1'b1;
		end

		out_valid_d = out_valid_q;
		if (rsp.ready) out_valid_d = 1'b0;
		if (out_load) out_valid_d = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_INIT;
			init_q       <= '0;
			free_head_q  <= NW'(1);
			free_count_q <= POOL_N;
			head_q[0]    <= '0;
			head_q[1]    <= '0;
			tail_q[0]    <= '0;
			tail_q[1]    <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q      <= state_d;
			init_q       <= init_d;
			free_head_q  <= free_head_d;
			free_count_q <= free_count_d;
			head_q       <= head_d;
			tail_q       <= tail_d;
			out_valid_q  <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		sel_q        <= sel_d;
		key_q        <= key_d;
		cur_q        <= cur_d;
		prev_q       <= prev_d;
		steps_q      <= steps_d;
		last_q       <= last_d;
		first_q      <= first_d;
		total_q      <= total_d;
		cnt_q        <= cnt_d;
		res_status_q <= res_status_d;
		res_aff_q    <= res_aff_d;
		res_cnt_q    <= res_cnt_d;
		res_key_q    <= res_key_d;
		res_next_q   <= res_next_d;
		res_own_q    <= res_own_d;
		if (out_load) begin
			rsp.status        <= res_status_q;
			rsp.affected_node <= res_aff_q;
			rsp.node_count    <= res_cnt_q;
			rsp.read_key      <= res_key_q;
			rsp.read_next     <= res_next_q;
			rsp.read_owner    <= res_own_q;
		end
	end

	assign rsp.valid = out_valid_q;

endmodule
